// ----- rtl/pmm_pkg.sv -----
// Shared constants, operation codes and interface structs of the periodic pattern matcher.
package pmm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int MAX_TEXT    = 4096;
    localparam int PAT_AW      = 6;
    localparam int TXT_AW      = 12;
    localparam int WIT_DEPTH   = 32;

    localparam logic [1:0] OP_LOAD_PAT = 2'd0;
    localparam logic [1:0] OP_LOAD_TXT = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] CFG_PERIOD         = 2'd1;
    localparam logic [1:0] CFG_TEXT_LENGTH    = 2'd2;

    typedef struct packed {
        logic [6:0]  m;
        logic [5:0]  p;
        logic [12:0] n;
    } t_run_cfg;

    typedef struct packed {
        logic        done;
        logic [11:0] position;
        logic        valid_res;
        logic [12:0] count;
    } t_eng_res;

endpackage

// ----- rtl/periodic_pattern_matcher.sv -----
// Top level of the periodic pattern matcher: handshakes, configuration registers, result register.
//
// Loads pattern and text bytes by index, runs a witness-and-duel search for a periodic
// pattern (length m, period p, m >= 2p) over the first n text bytes, and reads matches back
// by list index; every word in gives one word out carrying the current match count. A load
// or an out-of-range read steps straight to the done state; an in-range read passes first
// through a read state for the registered match memory read. The result word is registered
// from the done state. A run is one shared byte comparator stepping under the sequencer,
// each compare with an address state and a compare state: divide m by p, clear n marks,
// find witnesses, duel each block of p and verify its candidate, check the 2p + m mod p
// bytes at each survivor and mark it, then scan the marks by stride p. The input is stalled
// while any word is in work and while a finished result waits on a stalled output.
// Configuration is taken at any time with ready high and must be written only while idle;
// out-of-range lengths are saturated when a run starts.
module periodic_pattern_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_index,
    input  logic [7:0]  i_symbol,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_match_count,
    output logic [11:0] o_position,
    output logic        o_valid_res,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    pmm_pkg::t_run_cfg r_cfg;
    pmm_pkg::t_eng_res eng_res;
    logic              eng_busy;
    logic              in_acc;
    logic              r_out_valid;
    logic [12:0]       r_out_count;
    logic [11:0]       r_out_pos;
    logic              r_out_vres;

    // engine must be idle and the result slot free (or draining) to take a word
    assign o_in_stall  = eng_busy | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    // config registers hold the raw written value; saturation happens per run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m <= 7'd2;
            r_cfg.p <= 6'd1;
            r_cfg.n <= 13'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pmm_pkg::CFG_PATTERN_LENGTH: r_cfg.m <= i_cfg_data[6:0];
                pmm_pkg::CFG_PERIOD:         r_cfg.p <= i_cfg_data[5:0];
                pmm_pkg::CFG_TEXT_LENGTH:    r_cfg.n <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pmm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_op     (i_operation),
        .i_index  (i_index),
        .i_symbol (i_symbol),
        .i_cfg    (r_cfg),
        .o_busy   (eng_busy),
        .o_res    (eng_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res.done) begin
            r_out_count <= eng_res.count;
            r_out_pos   <= eng_res.position;
            r_out_vres  <= eng_res.valid_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_position    = r_out_pos;
    assign o_valid_res   = r_out_vres;

    // a finished word never lands on an undelivered one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_res.done |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten");

    // an accepted word keeps the engine busy on the next cycle
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> eng_busy)
        else $error("engine not busy after accept");

    // a valid read needs a nonzero match count
    a_valid_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (o_match_count != 13'd0))
        else $error("valid read with zero count");

endmodule

// ----- rtl/pmm_engine.sv -----
// Search engine: symbol stores, witness table, survivor/mark/match stores and the run sequencer.
module pmm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  logic [11:0]       i_index,
    input  logic [7:0]        i_symbol,
    input  pmm_pkg::t_run_cfg i_cfg,
    output logic              o_busy,
    output pmm_pkg::t_eng_res o_res
);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_SETUP     = 5'd1;
    localparam logic [4:0] ST_DIV       = 5'd2;
    localparam logic [4:0] ST_CLR       = 5'd3;
    localparam logic [4:0] ST_WIT_ADDR  = 5'd4;
    localparam logic [4:0] ST_WIT_CMP   = 5'd5;
    localparam logic [4:0] ST_DUEL_ADDR = 5'd6;
    localparam logic [4:0] ST_DUEL_CMP  = 5'd7;
    localparam logic [4:0] ST_VER_ADDR  = 5'd8;
    localparam logic [4:0] ST_VER_CMP   = 5'd9;
    localparam logic [4:0] ST_MARK_RD   = 5'd10;
    localparam logic [4:0] ST_MARK_CHK  = 5'd11;
    localparam logic [4:0] ST_MARK_ADDR = 5'd12;
    localparam logic [4:0] ST_MARK_CMP  = 5'd13;
    localparam logic [4:0] ST_ACC_ADDR  = 5'd14;
    localparam logic [4:0] ST_ACC_CMP   = 5'd15;
    localparam logic [4:0] ST_READ      = 5'd16;
    localparam logic [4:0] ST_DONE      = 5'd17;

    // memories
    logic [7:0]  r_text_mem  [0:pmm_pkg::MAX_TEXT-1];
    logic [7:0]  r_pat_mem   [0:pmm_pkg::MAX_PATTERN-1];
    logic [11:0] r_surv_mem  [0:pmm_pkg::MAX_TEXT-1];
    logic [11:0] r_match_mem [0:pmm_pkg::MAX_TEXT-1];
    logic        r_mark_mem  [0:pmm_pkg::MAX_TEXT-1];
    logic [5:0]  r_wit       [0:pmm_pkg::WIT_DEPTH-1];

    logic [7:0]  r_text_q, r_pat_qa, r_pat_qb;
    logic [11:0] r_surv_q, r_match_q;
    logic        r_mark_q;

    logic        text_we, pat_we, surv_we, match_we, mark_we, wit_we;
    logic [11:0] text_waddr, text_raddr, surv_waddr, surv_raddr;
    logic [11:0] match_waddr, match_raddr, mark_waddr, mark_raddr;
    logic [5:0]  pat_waddr, pat_ra, pat_rb;
    logic [4:0]  wit_waddr;
    logic [7:0]  text_wd, pat_wd;
    logic [11:0] surv_wd, match_wd;
    logic        mark_wd;
    logic [5:0]  wit_wd;

    // sequencer registers
    logic [4:0]  r_state, n_state;
    logic [6:0]  r_plen, n_plen, r_q, n_q, r_rem, n_rem, r_ulen, n_ulen;
    logic [6:0]  r_t, n_t, r_k, n_k;
    logic [5:0]  r_p, n_p;
    logic [12:0] r_n, n_n, r_nb, n_nb, r_i, n_i, r_cnt, n_cnt, r_found, n_found;
    logic [4:0]  r_s, n_s, r_tp, n_tp, r_r, n_r;
    logic [13:0] r_b, n_b, r_j, n_j, r_x, n_x;
    logic [11:0] r_w, n_w, r_c, n_c, r_pos, n_pos;
    logic        r_vld, n_vld;

    logic [6:0]  sat_m;
    logic [5:0]  sat_p;
    logic [12:0] sat_n;
    logic [13:0] blk_end, blk_lim, blk_next, duel_diff, duel_pos;
    logic [5:0]  duel_k;
    logic        go_next_block, go_acc_init, go_next_j;

    always_comb begin
        sat_m = (i_cfg.m < 7'd2) ? 7'd2 :
                (i_cfg.m > 7'(pmm_pkg::MAX_PATTERN)) ? 7'(pmm_pkg::MAX_PATTERN) : i_cfg.m;
        sat_p = (i_cfg.p == 6'd0) ? 6'd1 :
                (7'(i_cfg.p) > (sat_m >> 1)) ? sat_m[6:1] : i_cfg.p;
        sat_n = (i_cfg.n == 13'd0) ? 13'd1 :
                (i_cfg.n > 13'(pmm_pkg::MAX_TEXT)) ? 13'(pmm_pkg::MAX_TEXT) : i_cfg.n;
        blk_end   = r_b + 14'(r_p);
        blk_lim   = (blk_end < 14'(r_n)) ? blk_end : 14'(r_n);
        blk_next  = r_b + 14'(r_p);
        duel_diff = r_j - 14'(r_w);
        duel_k    = r_wit[duel_diff[4:0]];
        duel_pos  = r_j + 14'(duel_k);
    end

    always_comb begin
        n_state = r_state;
        n_p = r_p; n_n = r_n; n_plen = r_plen; n_q = r_q; n_rem = r_rem;
        n_ulen = r_ulen; n_t = r_t; n_k = r_k; n_nb = r_nb; n_i = r_i; n_cnt = r_cnt;
        n_found = r_found; n_s = r_s; n_tp = r_tp; n_r = r_r; n_b = r_b; n_j = r_j;
        n_x = r_x; n_w = r_w; n_c = r_c; n_pos = r_pos; n_vld = r_vld;
        text_we = 1'b0; pat_we = 1'b0; surv_we = 1'b0; match_we = 1'b0;
        mark_we = 1'b0; wit_we = 1'b0;
        text_waddr = i_index; text_wd = i_symbol; text_raddr = '0;
        pat_waddr = i_index[5:0]; pat_wd = i_symbol; pat_ra = '0; pat_rb = '0;
        surv_waddr = r_nb[11:0]; surv_wd = r_w; surv_raddr = '0;
        match_waddr = r_cnt[11:0]; match_wd = r_j[11:0]; match_raddr = i_index;
        mark_waddr = r_x[11:0]; mark_wd = 1'b0; mark_raddr = '0;
        wit_waddr = r_s; wit_wd = '0;
        go_next_block = 1'b0; go_acc_init = 1'b0; go_next_j = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_pos = '0;
                    n_vld = 1'b0;
                    case (i_op)
                        pmm_pkg::OP_LOAD_PAT: begin
                            pat_we  = (i_index[11:6] == 6'd0);
                            n_state = ST_DONE;
                        end
                        pmm_pkg::OP_LOAD_TXT: begin
                            text_we = 1'b1;
                            n_state = ST_DONE;
                        end
                        pmm_pkg::OP_RUN: begin
                            n_state = ST_SETUP;
                        end
                        default: begin
                            if (13'(i_index) < r_found) begin
                                n_vld   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n_p = sat_p; n_n = sat_n;
                n_q = '0; n_rem = sat_m; n_cnt = '0; n_nb = '0;
                wit_we = 1'b1; wit_waddr = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // m / p and m mod p by repeated subtraction
                if (r_rem >= 7'(r_p)) begin
                    n_rem = r_rem - 7'(r_p);
                    n_q   = r_q + 7'd1;
                end else begin
                    n_ulen  = {r_p, 1'b0} + r_rem;
                    n_plen  = {r_p, 1'b0} - 7'd1;
                    n_x     = '0;
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                mark_we = 1'b1;
                n_x = r_x + 14'd1;
                if (r_x + 14'd1 >= 14'(r_n)) begin
                    n_s = 5'd1; n_t = '0;
                    if (r_p == 6'd1) begin
                        n_b = '0; n_j = '0; n_w = '0;
                        n_state = ST_DUEL_ADDR;
                    end else begin
                        n_state = ST_WIT_ADDR;
                    end
                end
            end
            ST_WIT_ADDR: begin
                if (r_t + 7'(r_s) < r_plen) begin
                    pat_ra  = r_t[5:0];
                    pat_rb  = 6'(r_s) + r_t[5:0];
                    n_state = ST_WIT_CMP;
                end else begin
                    wit_we = 1'b1;
                    if (6'(r_s) + 6'd1 == r_p) begin
                        n_b = '0; n_j = '0; n_w = '0;
                        n_state = ST_DUEL_ADDR;
                    end else begin
                        n_s = r_s + 5'd1; n_t = '0;
                    end
                end
            end
            ST_WIT_CMP: begin
                if (r_pat_qa != r_pat_qb) begin
                    wit_we = 1'b1;
                    wit_wd = r_t[5:0];
                    if (6'(r_s) + 6'd1 == r_p) begin
                        n_b = '0; n_j = '0; n_w = '0;
                        n_state = ST_DUEL_ADDR;
                    end else begin
                        n_s = r_s + 5'd1; n_t = '0;
                        n_state = ST_WIT_ADDR;
                    end
                end else begin
                    n_t = r_t + 7'd1;
                    n_state = ST_WIT_ADDR;
                end
            end
            ST_DUEL_ADDR: begin
                if (r_j >= blk_lim) begin
                    if (14'(r_w) + 14'(r_plen) > 14'(r_n)) begin
                        go_next_block = 1'b1;
                    end else begin
                        n_t = '0;
                        n_state = ST_VER_ADDR;
                    end
                end else if (duel_pos < 14'(r_n)) begin
                    text_raddr = duel_pos[11:0];
                    pat_ra     = duel_k;
                    n_state    = ST_DUEL_CMP;
                end else begin
                    n_j = r_j + 14'd1;
                end
            end
            ST_DUEL_CMP: begin
                if (r_text_q == r_pat_qa) n_w = r_j[11:0];
                n_j = r_j + 14'd1;
                n_state = ST_DUEL_ADDR;
            end
            ST_VER_ADDR: begin
                if (r_t < r_plen) begin
                    text_raddr = r_w + 12'(r_t);
                    pat_ra     = r_t[5:0];
                    n_state    = ST_VER_CMP;
                end else begin
                    surv_we = 1'b1;
                    n_nb = r_nb + 13'd1;
                    go_next_block = 1'b1;
                end
            end
            ST_VER_CMP: begin
                if (r_text_q != r_pat_qa) begin
                    go_next_block = 1'b1;
                end else begin
                    n_t = r_t + 7'd1;
                    n_state = ST_VER_ADDR;
                end
            end
            ST_MARK_RD: begin
                if (r_i >= r_nb) begin
                    go_acc_init = 1'b1;
                end else begin
                    surv_raddr = r_i[11:0];
                    n_state = ST_MARK_CHK;
                end
            end
            ST_MARK_CHK: begin
                if (14'(r_surv_q) + 14'(r_ulen) > 14'(r_n)) begin
                    go_acc_init = 1'b1;
                end else begin
                    n_c = r_surv_q; n_t = '0; n_tp = '0;
                    n_state = ST_MARK_ADDR;
                end
            end
            ST_MARK_ADDR: begin
                if (r_t < r_ulen) begin
                    text_raddr = r_c + 12'(r_t);
                    pat_ra     = 6'(r_tp);
                    n_state    = ST_MARK_CMP;
                end else begin
                    mark_we = 1'b1; mark_waddr = r_c; mark_wd = 1'b1;
                    n_i = r_i + 13'd1;
                    n_state = ST_MARK_RD;
                end
            end
            ST_MARK_CMP: begin
                if (r_text_q != r_pat_qa) begin
                    n_i = r_i + 13'd1;
                    n_state = ST_MARK_RD;
                end else begin
                    n_t  = r_t + 7'd1;
                    n_tp = (6'(r_tp) + 6'd1 == r_p) ? 5'd0 : r_tp + 5'd1;
                    n_state = ST_MARK_ADDR;
                end
            end
            ST_ACC_ADDR: begin
                if (r_j >= 14'(r_n)) begin
                    // residue exhausted
                    if (6'(r_r) + 6'd1 == r_p) begin
                        n_found = r_cnt;
                        n_state = ST_DONE;
                    end else begin
                        n_r = r_r + 5'd1;
                        n_j = 14'(r_r) + 14'd1;
                        n_x = 14'(r_r) + 14'd1;
                        n_k = '0;
                    end
                end else if (r_k + 7'd1 >= r_q) begin
                    match_we = 1'b1;
                    n_cnt = r_cnt + 13'd1;
                    go_next_j = 1'b1;
                end else if (r_x >= 14'(r_n)) begin
                    go_next_j = 1'b1;
                end else begin
                    mark_raddr = r_x[11:0];
                    n_state = ST_ACC_CMP;
                end
            end
            ST_ACC_CMP: begin
                if (!r_mark_q) begin
                    go_next_j = 1'b1;
                end else begin
                    n_k = r_k + 7'd1;
                    n_x = r_x + 14'(r_p);
                end
                n_state = ST_ACC_ADDR;
            end
            ST_READ: begin
                n_pos = r_match_q;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (go_next_block) begin
            if (blk_next >= 14'(r_n)) begin
                n_i = '0;
                n_state = ST_MARK_RD;
            end else begin
                n_b = blk_next; n_j = blk_next; n_w = blk_next[11:0];
                n_state = ST_DUEL_ADDR;
            end
        end
        if (go_acc_init) begin
            n_r = '0; n_j = '0; n_x = '0; n_k = '0;
            n_state = ST_ACC_ADDR;
        end
        if (go_next_j) begin
            n_j = r_j + 14'(r_p);
            n_x = r_j + 14'(r_p);
            n_k = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_found <= '0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_n <= n_n; r_plen <= n_plen; r_q <= n_q; r_rem <= n_rem;
        r_ulen <= n_ulen; r_t <= n_t; r_k <= n_k; r_nb <= n_nb; r_i <= n_i; r_cnt <= n_cnt;
        r_s <= n_s; r_tp <= n_tp; r_r <= n_r; r_b <= n_b; r_j <= n_j; r_x <= n_x;
        r_w <= n_w; r_c <= n_c; r_pos <= n_pos; r_vld <= n_vld;
    end

    always_ff @(posedge i_clk) begin
        if (text_we) r_text_mem[text_waddr] <= text_wd;
        r_text_q <= r_text_mem[text_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) r_pat_mem[pat_waddr] <= pat_wd;
        r_pat_qa <= r_pat_mem[pat_ra];
        r_pat_qb <= r_pat_mem[pat_rb];
    end

    always_ff @(posedge i_clk) begin
        if (surv_we) r_surv_mem[surv_waddr] <= surv_wd;
        r_surv_q <= r_surv_mem[surv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (match_we) r_match_mem[match_waddr] <= match_wd;
        r_match_q <= r_match_mem[match_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) r_mark_mem[mark_waddr] <= mark_wd;
        r_mark_q <= r_mark_mem[mark_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wit_we) r_wit[wit_waddr] <= wit_wd;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_res.done      = (r_state == ST_DONE);
    assign o_res.position  = r_pos;
    assign o_res.valid_res = r_vld;
    assign o_res.count     = r_found;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the periodic pattern matcher: random words, shadow search model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // ---------------------------------------------------------------
    // Result word as it leaves the block
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [12:0] count;
        logic [11:0] position;
        logic        valid_res;
    } t_match_word;

    // ---------------------------------------------------------------
    // Scoreboard: shadow copy of the search state and a queue of
    // expected result words, one per accepted input word.
    // ---------------------------------------------------------------
    class match_scoreboard;
        logic [7:0]  pat_mem[pmm_pkg::MAX_PATTERN];
        logic [7:0]  txt_mem[pmm_pkg::MAX_TEXT];
        logic [11:0] hits[pmm_pkg::MAX_TEXT];
        int          hit_total;
        int          reg_m, reg_p, reg_n;
        t_match_word pending[$];
        int          errors;

        function new();
            foreach (pat_mem[i]) pat_mem[i] = '0;
            foreach (txt_mem[i]) txt_mem[i] = '0;
            hit_total = 0;
            reg_m = 2;
            reg_p = 1;
            reg_n = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                pmm_pkg::CFG_PATTERN_LENGTH: reg_m = data[6:0];
                pmm_pkg::CFG_PERIOD:         reg_p = data[5:0];
                pmm_pkg::CFG_TEXT_LENGTH:    reg_n = data;
                default: ;
            endcase
        endfunction

        // full search: witnesses, block duels, verify, u u v marks, stride scan
        function void search();
            int m, p, n, plen, ulen, q, nb, w, wend, k, c, x;
            int wit[32];
            int surv[$];
            bit mark[pmm_pkg::MAX_TEXT];
            bit ok;
            m = reg_m;
            p = reg_p;
            n = reg_n;
            if (m < 2) m = 2;
            if (m > pmm_pkg::MAX_PATTERN) m = pmm_pkg::MAX_PATTERN;
            if (p < 1) p = 1;
            if (p > m / 2) p = m / 2;
            if (n < 1) n = 1;
            if (n > pmm_pkg::MAX_TEXT) n = pmm_pkg::MAX_TEXT;
            plen = 2 * p - 1;
            wit[0] = 0;
            for (int s = 1; s < p; s++) begin
                wit[s] = 0;
                for (int t = 0; t + s < plen; t++) begin
                    if (pat_mem[t] != pat_mem[s + t]) begin
                        wit[s] = t;
                        break;
                    end
                end
            end
            for (int b = 0; b < n; b += p) begin
                w = b;
                wend = (b + p > n) ? n : b + p;
                for (int j = b; j < wend; j++) begin
                    k = wit[j - w];
                    if (j + k < n && txt_mem[j + k] == pat_mem[k]) w = j;
                end
                ok = (w + plen <= n);
                for (int t = 0; ok && t < plen; t++)
                    if (txt_mem[w + t] != pat_mem[t]) ok = 0;
                if (ok) surv.insert(surv.size(), w);
            end
            foreach (mark[i]) mark[i] = 0;
            ulen = 2 * p + m % p;
            foreach (surv[i]) begin
                c = surv[i];
                if (c + ulen > n) break;
                ok = 1;
                for (int t = 0; ok && t < ulen; t++)
                    if (txt_mem[c + t] != pat_mem[t % p]) ok = 0;
                if (ok) mark[c] = 1;
            end
            q = m / p;
            hit_total = 0;
            for (int r = 0; r < p; r++) begin
                for (int j = r; j < n; j += p) begin
                    ok = 1;
                    for (int kk = 0; ok && kk + 1 < q; kk++) begin
                        x = j + kk * p;
                        if (x >= n || !mark[x]) ok = 0;
                    end
                    if (ok) begin
                        hits[hit_total] = 12'(j);
                        hit_total++;
                    end
                end
            end
        endfunction

        function void note_word(logic [1:0] op, logic [11:0] idx, logic [7:0] sym);
            t_match_word e;
            e.position = '0;
            e.valid_res = 1'b0;
            case (op)
                pmm_pkg::OP_LOAD_PAT: if (idx < pmm_pkg::MAX_PATTERN) pat_mem[idx] = sym;
                pmm_pkg::OP_LOAD_TXT: txt_mem[idx] = sym;
                pmm_pkg::OP_RUN:      search();
                pmm_pkg::OP_READ: begin
                    if (idx < hit_total) begin
                        e.position = hits[idx];
                        e.valid_res = 1'b1;
                    end
                end
                default: ;
            endcase
            e.count = 13'(hit_total);
            pending.insert(pending.size(), e);
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_word(t_match_word got);
            t_match_word e;
            if (pending.size() == 0) begin
                report("unexpected word, count", got.count, -1);
                return;
            end
            e = pending.pop_front();
            if (got.count !== e.count) report("match_count", got.count, e.count);
            if (got.position !== e.position) report("position", got.position, e.position);
            if (got.valid_res !== e.valid_res) report("valid_res", got.valid_res, e.valid_res);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [11:0] i_index;
    logic [7:0]  i_symbol;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [12:0] o_match_count;
    logic [11:0] o_position;
    logic        o_valid_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    periodic_pattern_matcher i_dut (.*);

    match_scoreboard sb;
    bit quiet_tail;      // no idling near the end
    bit hold_sink;       // long receiver hold-off in progress
    int hold_cycles;
    int words_sent;

    // shadow copies used by the stimulus to build matching texts
    int cur_m, cur_p, cur_n;
    logic [7:0] cur_pat[pmm_pkg::MAX_PATTERN];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Limit: a watchdog far beyond the length of a correct run
    initial begin
        #400ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int gap;
        i_out_stall <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_sink = 0;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    // result words are checked at the edge they are accepted
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word({o_match_count, o_position, o_valid_res});
    end

    // ---------------------------------------------------------------
    // Sender tasks
    // ---------------------------------------------------------------
    task automatic send_word(logic [1:0] op, logic [11:0] idx, logic [7:0] sym);
        int gap;
        // occasional idle burst before the word
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_index     <= idx;
        i_symbol    <= sym;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(op, idx, sym);
        words_sent++;
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 5000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // set registers; drained first so the block is idle
    task automatic set_shape(int m, int p, int n);
        drain();
        write_reg(pmm_pkg::CFG_PATTERN_LENGTH, 13'(m));
        write_reg(pmm_pkg::CFG_PERIOD, 13'(p));
        write_reg(pmm_pkg::CFG_TEXT_LENGTH, 13'(n));
        i_cfg_valid <= 1'b0;
        cur_m = (m < 2) ? 2 : (m > pmm_pkg::MAX_PATTERN ? pmm_pkg::MAX_PATTERN : m);
        cur_p = (p < 1) ? 1 : (p > cur_m / 2 ? cur_m / 2 : p);
        cur_n = (n < 1) ? 1 : (n > pmm_pkg::MAX_TEXT ? pmm_pkg::MAX_TEXT : n);
    endtask

    // pattern with minimal period p: random u, fixed so no smaller period divides it
    task automatic load_pattern();
        logic [7:0] u[32];
        for (int i = 0; i < cur_p; i++) u[i] = 8'($urandom_range(0, 3));
        if (cur_p > 1) u[cur_p - 1] = u[0] ^ 8'hA5;
        for (int i = 0; i < cur_m; i++) begin
            cur_pat[i] = u[i % cur_p];
            send_word(pmm_pkg::OP_LOAD_PAT, 12'(i), cur_pat[i]);
        end
    endtask

    // text: mostly pattern repetitions with random breaks; every index written
    task automatic load_text(int noise);
        logic [7:0] s;
        int k;
        k = 0;
        for (int i = 0; i < cur_n; i++) begin
            if ($urandom_range(0, 99) < noise) begin
                s = 8'($urandom_range(0, 255));
                k = $urandom_range(0, cur_p - 1);
            end else begin
                s = cur_pat[k % cur_p];
                k++;
            end
            send_word(pmm_pkg::OP_LOAD_TXT, 12'(i), s);
        end
    endtask

    task automatic read_some(int cnt);
        for (int i = 0; i < cnt; i++)
            send_word(pmm_pkg::OP_READ,
                      (i % 5 == 4) ? 12'($urandom_range(0, 4095)) : 12'(i), 8'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        quiet_tail = 0;
        hold_sink = 0;
        words_sent = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= pmm_pkg::OP_READ;
        i_index     <= '0;
        i_symbol    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pmm_pkg::CFG_PATTERN_LENGTH;
        i_cfg_data  <= '0;
        cur_m = 2;
        cur_p = 1;
        cur_n = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, extreme field values, every operation
        send_word(pmm_pkg::OP_LOAD_PAT, 0, 8'h00);
        send_word(pmm_pkg::OP_LOAD_PAT, 1, 8'hFF);
        send_word(pmm_pkg::OP_LOAD_PAT, 12'hFFF, 8'hFF);   // out of range, ignored
        send_word(pmm_pkg::OP_LOAD_TXT, 0, 8'h00);
        send_word(pmm_pkg::OP_LOAD_TXT, 12'hFFF, 8'hFF);
        send_word(pmm_pkg::OP_RUN, 12'hFFF, 8'hFF);
        send_word(pmm_pkg::OP_READ, 0, 8'h00);
        send_word(pmm_pkg::OP_READ, 12'hFFF, 8'hFF);        // read past count

        // out-of-range registers saturate: m below 2, p above m/2, n zero
        set_shape(0, 63, 0);
        load_pattern();
        send_word(pmm_pkg::OP_LOAD_TXT, 0, cur_pat[0]);
        send_word(pmm_pkg::OP_RUN, 0, 0);
        read_some(2);

        // minimum sizes, all-equal text: every position where the pattern fits matches
        set_shape(2, 1, 16);
        load_pattern();
        load_text(0);
        send_word(pmm_pkg::OP_RUN, 0, 0);
        read_some(6);

        // sender pauses until every expected word has come
        drain();

        // long receiver hold-off while the sender keeps offering words
        hold_cycles = 300;
        hold_sink = 1;
        read_some(12);

        // random phases over several shapes, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            int m, p, n;
            case (ph)
                0: begin m = 64; p = 32; n = 66; end
                1: begin m = 127; p = 0; n = 30; end   // saturates to 64, 1
                2: begin m = 9;  p = 4;  n = 60; end
                default: begin
                    m = $urandom_range(2, 16);
                    p = $urandom_range(1, m / 2);
                    n = $urandom_range(1, 40);
                end
            endcase
            set_shape(m, p, n);
            load_pattern();
            load_text(ph == 2 ? 1 : $urandom_range(0, 15));
            if (ph >= 4) quiet_tail = 1;
            send_word(pmm_pkg::OP_RUN, 12'($urandom), 8'($urandom));
            read_some($urandom_range(6, 20));
        end
        // operations on a text that has been loaded only: every index below n written
        send_word(pmm_pkg::OP_LOAD_TXT, 12'hFFF, 8'h5A);
        send_word(pmm_pkg::OP_RUN, 0, 0);
        read_some(4);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
